### hdl/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg: shared types and constants for the 5x5 pyramid reduce core
// widths, queue geometry and the front-to-back transfer record
// ----------------------------------------------------------------------------
package gpr_pkg;

  // image limits
  localparam int MAX_COLUMNS  = 2048;
  localparam int MAX_ROWS     = 4096;
  localparam int MAX_COLORS   = 4;
  localparam int KERNEL_TAPS  = 5;
  localparam int LINE_SLOTS   = KERNEL_TAPS - 1;
  localparam int LINE_WORDS   = MAX_COLUMNS * MAX_COLORS;
  localparam int LINE_AW      = $clog2(LINE_WORDS);

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 13;

  // field widths
  localparam int SAMPLE_W = 8;
  localparam int TCOL_W   = 10;
  localparam int TROW_W   = 11;
  localparam int CH_W     = 2;
  localparam int VSUM_W   = 13;   // 20 * 255 fits
  localparam int ACC_W    = 17;   // 400 * 255 fits

  // divide by 400: drop four bits, then multiply by ceil(2^17 / 25)
  localparam int DIV_PRE_SHIFT = 4;
  localparam int DIV25_SHIFT   = 17;
  localparam int DIV25_MUL     = 5243;
  localparam int PROD_W        = 26;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [KERNEL_TAPS-1:0][SAMPLE_W-1:0] taps;  // [0] oldest line, [4] new sample
    logic [CH_W-1:0]                      ch;
    logic                                 emit;
    logic [TCOL_W-1:0]                    tc;
    logic [TROW_W-1:0]                    tr;
    logic                                 last;
  } qitem_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
    logic            empty;
  } qstat_t;

endpackage

### hdl/gpr_front.sv
// ----------------------------------------------------------------------------
// gpr_front: raster position tracking, classification and line store
// takes one sample per cycle unless in_stall, reads the four older lines and queues a column
// ----------------------------------------------------------------------------
module gpr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [gpr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [gpr_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gpr_pkg::SAMPLE_W-1:0] in_sample,
  input  gpr_pkg::qstat_t              q_stat,
  output logic                         q_push,
  output gpr_pkg::qitem_t              q_item
);
  import gpr_pkg::*;

  localparam logic [CFG_IW-1:0] REG_SOURCE_COLUMNS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SOURCE_ROWS    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_COLOR_COUNT    = 2'd2;

  // effective (saturated) configuration
  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  colors_r;

  logic [10:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [1:0]  ch_r,  ch_nxt;

  logic accept;

  // stage a: line store read in flight
  logic                               a_valid_r;
  logic [SAMPLE_W-1:0]                a_sample_r;
  logic [1:0]                         a_slot_r;
  logic [CH_W-1:0]                    a_ch_r;
  logic                               a_emit_r;
  logic [TCOL_W-1:0]                  a_tc_r;
  logic [TROW_W-1:0]                  a_tr_r;
  logic                               a_last_r;
  logic [LINE_SLOTS-1:0][SAMPLE_W-1:0] rd_r;

  // one word per position holds that position in all four lines
  logic [LINE_SLOTS-1:0][SAMPLE_W-1:0] line_mem [LINE_WORDS];

  logic [10:0]       tcols;
  logic [11:0]       trows;
  logic [10:0]       col_m2;
  logic [11:0]       row_m2;
  logic [TCOL_W-1:0] tc;
  logic [TROW_W-1:0] tr;
  logic              ch_wrap;
  logic              emit;
  logic              last;
  logic [LINE_AW-1:0] addr;

  // room for the item in stage a plus the new one
  assign in_stall = ({1'b0, q_stat.count} + {{Q_CW{1'b0}}, a_valid_r}) >= (Q_CW + 1)'(Q_DEPTH);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 13'd480;
      colors_r <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_COLUMNS: begin
          width_r <= (cfg_data[11:0] > 12'(MAX_COLUMNS)) ? 12'(MAX_COLUMNS) : cfg_data[11:0];
        end
        REG_SOURCE_ROWS: begin
          height_r <= (cfg_data > 13'(MAX_ROWS)) ? 13'(MAX_ROWS) : cfg_data;
        end
        REG_COLOR_COUNT: begin
          if (cfg_data[2:0] == 3'd0) colors_r <= 3'd1;
          else if (cfg_data[2:0] > 3'(MAX_COLORS)) colors_r <= 3'(MAX_COLORS);
          else colors_r <= cfg_data[2:0];
        end
        default: begin
        end
      endcase
    end
  end

  // raster position advance
  assign ch_wrap = ({1'b0, ch_r} + 3'd1) >= colors_r;

  always_comb begin
    ch_nxt  = ch_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (ch_wrap) begin
      ch_nxt = '0;
      if (({1'b0, col_r} + 12'd1) >= width_r) begin
        col_nxt = '0;
        row_nxt = (({1'b0, row_r} + 13'd1) >= height_r) ? '0 : row_r + 12'd1;
      end else begin
        col_nxt = col_r + 11'd1;
      end
    end else begin
      ch_nxt = ch_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // classification of the current source position
  assign tcols  = width_r[11:1];
  assign trows  = height_r[12:1];
  assign col_m2 = col_r - 11'd2;
  assign row_m2 = row_r - 12'd2;
  assign tc     = col_m2[10:1];
  assign tr     = row_m2[11:1];

  assign emit = !col_r[0] && !row_r[0] && (col_r >= 11'd4) && (row_r >= 12'd4) &&
                (tcols >= 11'd3) && (trows >= 12'd3) &&
                ({1'b0, tc} <= tcols - 11'd2) && ({1'b0, tr} <= trows - 12'd2);
  assign last = ({1'b0, tc} == tcols - 11'd2) && ({1'b0, tr} == trows - 12'd2) && ch_wrap;

  assign addr = {col_r, ch_r};

  // line store: read-first, new sample overwrites the oldest line
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[addr];
      line_mem[addr][row_r[1:0]] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else        a_valid_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample_r <= in_sample;
      a_slot_r   <= row_r[1:0];
      a_ch_r     <= ch_r;
      a_emit_r   <= emit;
      a_tc_r     <= tc;
      a_tr_r     <= tr;
      a_last_r   <= last;
    end
  end

  // column of five: slot of row-4 first, up to row-1, then the new sample
  always_comb begin
    for (int j = 0; j < LINE_SLOTS; j++) begin
      q_item.taps[j] = rd_r[a_slot_r + 2'(j)];
    end
    q_item.taps[LINE_SLOTS] = a_sample_r;
    q_item.ch   = a_ch_r;
    q_item.emit = a_emit_r;
    q_item.tc   = a_tc_r;
    q_item.tr   = a_tr_r;
    q_item.last = a_last_r;
  end

  assign q_push = a_valid_r;

endmodule

### hdl/gpr_queue.sv
// ----------------------------------------------------------------------------
// gpr_queue: short fifo between front and back
// register based, head visible without a read cycle
// ----------------------------------------------------------------------------
module gpr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  gpr_pkg::qitem_t push_item,
  input  logic            pop,
  output gpr_pkg::qitem_t pop_item,
  output gpr_pkg::qstat_t stat
);
  import gpr_pkg::*;

  qitem_t           entry_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r;
  logic [Q_AW-1:0]  rp_r;
  logic [Q_CW-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + Q_AW'(1);
      if (pop)  rp_r <= rp_r + Q_AW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + Q_CW'(1);
        2'b01:   count_r <= count_r - Q_CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wp_r] <= push_item;
  end

  assign pop_item   = entry_r[rp_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

endmodule

### hdl/gpr_back.sv
// ----------------------------------------------------------------------------
// gpr_back: separable 1-5-8-5-1 filter, divide by 400, result register
// vertical sum, per-channel column history, reciprocal multiply, output
// ----------------------------------------------------------------------------
module gpr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gpr_pkg::qitem_t              q_item,
  input  gpr_pkg::qstat_t              q_stat,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gpr_pkg::SAMPLE_W-1:0] out_pixel_value,
  output logic [gpr_pkg::TCOL_W-1:0]   out_target_column,
  output logic [gpr_pkg::TROW_W-1:0]   out_target_row,
  output logic [gpr_pkg::CH_W-1:0]     out_channel,
  output logic                         out_frame_last
);
  import gpr_pkg::*;

  // a + 5b + 8c + 5d + e
  function automatic logic [ACC_W-1:0] tap_sum(
    input logic [VSUM_W-1:0] a, input logic [VSUM_W-1:0] b, input logic [VSUM_W-1:0] c,
    input logic [VSUM_W-1:0] d, input logic [VSUM_W-1:0] e);
    logic [ACC_W-1:0] bd;
    bd = ACC_W'(b) + ACC_W'(d);
    return ACC_W'(a) + ACC_W'(e) + (bd << 2) + bd + (ACC_W'(c) << 3);
  endfunction

  logic adv;

  logic              s1_valid_r;
  logic [VSUM_W-1:0] s1_vsum_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic              s1_emit_r;
  logic [TCOL_W-1:0] s1_tc_r;
  logic [TROW_W-1:0] s1_tr_r;
  logic              s1_last_r;

  logic [LINE_SLOTS-1:0][VSUM_W-1:0] hist_r [MAX_COLORS];
  logic [LINE_SLOTS-1:0][VSUM_W-1:0] hist_cur;
  logic [ACC_W-1:0]                  acc;
  logic [ACC_W-1:0]                  vsum_full;

  logic                            s2_valid_r;
  logic [ACC_W-DIV_PRE_SHIFT-1:0]  s2_acc_r;
  logic [CH_W-1:0]                 s2_ch_r;
  logic                            s2_emit_r;
  logic [TCOL_W-1:0]               s2_tc_r;
  logic [TROW_W-1:0]               s2_tr_r;
  logic                            s2_last_r;

  logic              s3_valid_r;
  logic [PROD_W-1:0] s3_prod_r;
  logic [CH_W-1:0]   s3_ch_r;
  logic [TCOL_W-1:0] s3_tc_r;
  logic [TROW_W-1:0] s3_tr_r;
  logic              s3_last_r;

  logic out_valid_r;

  // whole pipe holds while a finished result waits
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_stat.empty;

  assign vsum_full = tap_sum(VSUM_W'(q_item.taps[0]), VSUM_W'(q_item.taps[1]),
                             VSUM_W'(q_item.taps[2]), VSUM_W'(q_item.taps[3]),
                             VSUM_W'(q_item.taps[4]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_pop;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r && s2_emit_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // stage 1: vertical sum of the new column
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vsum_r <= vsum_full[VSUM_W-1:0];
      s1_ch_r   <= q_item.ch;
      s1_emit_r <= q_item.emit;
      s1_tc_r   <= q_item.tc;
      s1_tr_r   <= q_item.tr;
      s1_last_r <= q_item.last;
    end
  end

  // stage 2: horizontal sum over this channel's last five columns
  assign hist_cur = hist_r[s1_ch_r];
  assign acc = tap_sum(hist_cur[0], hist_cur[1], hist_cur[2], hist_cur[3], s1_vsum_r);

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      hist_r[s1_ch_r][0] <= hist_cur[1];
      hist_r[s1_ch_r][1] <= hist_cur[2];
      hist_r[s1_ch_r][2] <= hist_cur[3];
      hist_r[s1_ch_r][3] <= s1_vsum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_acc_r  <= acc[ACC_W-1:DIV_PRE_SHIFT];
      s2_ch_r   <= s1_ch_r;
      s2_emit_r <= s1_emit_r;
      s2_tc_r   <= s1_tc_r;
      s2_tr_r   <= s1_tr_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: divide by 25 through the reciprocal, exact below 43690
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_prod_r <= PROD_W'(s2_acc_r) * PROD_W'(DIV25_MUL);
      s3_ch_r   <= s2_ch_r;
      s3_tc_r   <= s2_tc_r;
      s3_tr_r   <= s2_tr_r;
      s3_last_r <= s2_last_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      out_pixel_value   <= s3_prod_r[DIV25_SHIFT +: SAMPLE_W];
      out_target_column <= s3_tc_r;
      out_target_row    <= s3_tr_r;
      out_channel       <= s3_ch_r;
      out_frame_last    <= s3_last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/gaussian_pyramid_reduce_5x5_core.sv
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_5x5_core: one level of a 5x5 image pyramid
// filters a channel-interleaved raster stream with 1-5-8-5-1 per axis, divides
// by 400 and keeps every second pixel of every second row
// ----------------------------------------------------------------------------
// path: the sample that completes a window goes through the stage a register,
//   the queue write, three filter stages and the output register
// throughput: one sample per cycle unless in_stall; line store takes a read
//   and a write per cycle, filter pipe moves a column per cycle unless stalled
// reset: position counters clear, configuration returns to 640 x 480 x 1;
//   line store and column history stay undefined until written, no clear pass
module gaussian_pyramid_reduce_5x5_core (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [gpr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [gpr_pkg::CFG_DW-1:0]   cfg_data,
  // sample stream in
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gpr_pkg::SAMPLE_W-1:0] in_sample,
  // reduced stream out
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gpr_pkg::SAMPLE_W-1:0] out_pixel_value,
  output logic [gpr_pkg::TCOL_W-1:0]   out_target_column,
  output logic [gpr_pkg::TROW_W-1:0]   out_target_row,
  output logic [gpr_pkg::CH_W-1:0]     out_channel,
  output logic                         out_frame_last
);
  import gpr_pkg::*;

  // front to queue
  logic   q_push;
  qitem_t q_push_item;
  // queue to back
  logic   q_pop;
  qitem_t q_head;
  qstat_t q_stat;

  logic in_xfer;

  assign in_xfer = in_valid && !in_stall;

  // front: counters, classification, line store; stalls only on queue credit
  gpr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  // decoupling queue, lets the front keep taking samples while out stalls
  gpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .pop_item  (q_head),
    .stat      (q_stat)
  );

  // back: filter arithmetic and the output register
  gpr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_item            (q_head),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_value   (out_pixel_value),
    .out_target_column (out_target_column),
    .out_target_row    (out_target_row),
    .out_channel       (out_channel),
    .out_frame_last    (out_frame_last)
  );

  // queue never overflows: credit check in the front must hold
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && !q_pop && (q_stat.count == Q_CW'(Q_DEPTH))))
    else $error("queue overflow");

  // every transferred sample is pushed into the queue in the next cycle
  a_xfer_push : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> q_push)
    else $error("accepted sample not queued");

  // back never pops an empty queue
  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_stat.count != '0))
    else $error("queue underflow");

endmodule

### verif/gpr_reduce_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpr_reduce_tb_pkg: register map and result record for the reduce testbench
// shared by the stimulus top and the prediction/compare module
// ----------------------------------------------------------------------------
package gpr_reduce_tb_pkg;

  typedef enum logic [gpr_pkg::CFG_IW-1:0] {
    REG_SOURCE_COLUMNS = 0,
    REG_SOURCE_ROWS    = 1,
    REG_COLOR_COUNT    = 2
  } gpr_reg_e;

  typedef struct packed {
    logic [gpr_pkg::SAMPLE_W-1:0] value;
    logic [gpr_pkg::TCOL_W-1:0]   tcol;
    logic [gpr_pkg::TROW_W-1:0]   trow;
    logic [gpr_pkg::CH_W-1:0]     ch;
    logic                         last;
  } reduced_px_t;

endpackage

### verif/gpr_reduce_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpr_reduce_checker: predicts and compares the reduced pixel stream
// mirrors the line store and 5x5 windows, queues the expected target pixels
// and checks every output transfer against the oldest one
// ----------------------------------------------------------------------------
module gpr_reduce_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [gpr_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [gpr_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [gpr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [gpr_pkg::SAMPLE_W-1:0] out_pixel_value,
  input  logic [gpr_pkg::TCOL_W-1:0]   out_target_column,
  input  logic [gpr_pkg::TROW_W-1:0]   out_target_row,
  input  logic [gpr_pkg::CH_W-1:0]     out_channel,
  input  logic                         out_frame_last,
  output int                           mismatch_count,
  output int                           outstanding
);
  import gpr_pkg::*;
  import gpr_reduce_tb_pkg::*;

  localparam int WEIGHT_TOTAL = 400;

  logic [11:0] src_cols;
  logic [12:0] src_rows;
  logic [2:0]  colors;

  logic [SAMPLE_W-1:0] line_mem [0:LINE_SLOTS*LINE_WORDS-1];
  logic [SAMPLE_W-1:0] window [0:MAX_COLORS-1][0:KERNEL_TAPS-1][0:KERNEL_TAPS-1];
  int unsigned next_col, next_row, next_ch;
  reduced_px_t expected_px [$];

  function automatic int unsigned tap_weight(input int unsigned tap);
    case (tap)
      0, 4:    return 1;
      1, 3:    return 5;
      default: return 8;
    endcase
  endfunction

  task automatic predict_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned w, h, nc, col, row, ch, d, r, k, acc, tc, tr, tcols, trows;
    logic [SAMPLE_W-1:0] fresh [0:KERNEL_TAPS-1];
    reduced_px_t px;
    w  = (src_cols > MAX_COLUMNS) ? MAX_COLUMNS : src_cols;
    h  = (src_rows > MAX_ROWS) ? MAX_ROWS : src_rows;
    nc = (colors == 0) ? 1 : ((colors > MAX_COLORS) ? MAX_COLORS : colors);
    col = next_col;
    row = next_row;
    ch  = next_ch;
    if (col >= MAX_COLUMNS || ch >= MAX_COLORS) begin
      col = 0;
      ch  = 0;
    end
    // older lines at this position, then the new sample goes in
    for (d = 1; d <= LINE_SLOTS; d++)
      fresh[LINE_SLOTS-d] =
        line_mem[((row + LINE_SLOTS - d) % LINE_SLOTS) * LINE_WORDS + col * MAX_COLORS + ch];
    fresh[LINE_SLOTS] = s;
    line_mem[(row % LINE_SLOTS) * LINE_WORDS + col * MAX_COLORS + ch] = s;
    for (r = 0; r < KERNEL_TAPS; r++) begin
      for (k = 0; k + 1 < KERNEL_TAPS; k++) window[ch][r][k] = window[ch][r][k+1];
      window[ch][r][KERNEL_TAPS-1] = fresh[r];
    end
    if (col % 2 == 0 && row % 2 == 0 && col >= 4 && row >= 4) begin
      tc    = (col - 2) / 2;
      tr    = (row - 2) / 2;
      tcols = w / 2;
      trows = h / 2;
      if (tcols >= 3 && trows >= 3 && tc <= tcols - 2 && tr <= trows - 2) begin
        acc = 0;
        for (r = 0; r < KERNEL_TAPS; r++)
          for (k = 0; k < KERNEL_TAPS; k++)
            acc += tap_weight(r) * tap_weight(k) * window[ch][r][k];
        px.value = SAMPLE_W'(acc / WEIGHT_TOTAL);
        px.tcol  = TCOL_W'(tc);
        px.trow  = TROW_W'(tr);
        px.ch    = CH_W'(ch);
        px.last  = (tc == tcols - 2 && tr == trows - 2 && ch + 1 >= nc);
        expected_px = {expected_px, px};
      end
    end
    if (ch + 1 >= nc) begin
      ch = 0;
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col++;
      end
    end else begin
      ch++;
    end
    next_col = col;
    next_row = row;
    next_ch  = ch;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    reduced_px_t want;
    if (!rst_n) begin
      src_cols = 12'd640;
      src_rows = 13'd480;
      colors   = 3'd1;
      next_col = 0;
      next_row = 0;
      next_ch  = 0;
      mismatch_count = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (window[c, r, k]) window[c][r][k] = '0;
      expected_px.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SOURCE_COLUMNS) src_cols = cfg_data[11:0];
        else if (cfg_index == REG_SOURCE_ROWS) src_rows = cfg_data[12:0];
        else if (cfg_index == REG_COLOR_COUNT) colors = cfg_data[2:0];
      end
      if (in_valid && !in_stall) predict_sample(in_sample);
      if (out_valid && !out_stall) begin
        if (expected_px.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual value %0d col %0d row %0d",
                   $time, out_pixel_value, out_target_column, out_target_row);
        end else begin
          want = expected_px.pop_front();
          check_field("pixel_value", 32'(want.value), 32'(out_pixel_value));
          check_field("target_column", 32'(want.tcol), 32'(out_target_column));
          check_field("target_row", 32'(want.trow), 32'(out_target_row));
          check_field("channel", 32'(want.ch), 32'(out_channel));
          check_field("frame_last", 32'(want.last), 32'(out_frame_last));
        end
      end
    end
    outstanding <= expected_px.size();
  end

endmodule

### verif/gaussian_pyramid_reduce_5x5_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_pyramid_reduce_5x5_core_tb: frame-level regression of the reduce core
// streams frames at many geometries, including the degenerate and the
// saturating ones, with random idle and stall on both channels; results are
// predicted and compared in the companion checker module
// ----------------------------------------------------------------------------
module gaussian_pyramid_reduce_5x5_core_tb;
  import gpr_pkg::*;
  import gpr_reduce_tb_pkg::*;

  typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_EXTREMES} fill_e;

  localparam int DRAIN_PAUSE  = 10;   // idle wait that lets the pipe drain
  localparam int DRAIN_LIMIT  = 5000;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CFG_IW-1:0]   cfg_index = '0;
  logic [CFG_DW-1:0]   cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_pixel_value;
  logic [TCOL_W-1:0]   out_target_column;
  logic [TROW_W-1:0]   out_target_row;
  logic [CH_W-1:0]     out_channel;
  logic                out_frame_last;

  // no idling on either side while this is high
  logic steady = 1'b0;
  int   mismatch_count;
  int   outstanding;

  gaussian_pyramid_reduce_5x5_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_value   (out_pixel_value),
    .out_target_column (out_target_column),
    .out_target_row    (out_target_row),
    .out_channel       (out_channel),
    .out_frame_last    (out_frame_last)
  );

  gpr_reduce_checker u_reduce_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_value   (out_pixel_value),
    .out_target_column (out_target_column),
    .out_target_row    (out_target_row),
    .out_channel       (out_channel),
    .out_frame_last    (out_frame_last),
    .mismatch_count    (mismatch_count),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver stalls on roughly one cycle in five, at random, unless steady
  always @(posedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(0, 99) < 19);
  end

  // one sample transfer; idle cycles are inserted ahead of it at random and
  // valid stays up with a frozen sample until the core takes it
  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] fill_value(input fill_e mode);
    case (mode)
      FILL_WHITE:    return 8'hFF;
      FILL_BLACK:    return 8'h00;
      FILL_EXTREMES: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:       return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_samples(input int count, input fill_e mode);
    for (int i = 0; i < count; i++) push_sample(fill_value(mode));
  endtask

  // geometry changes only with the pipe empty: wait for every expected pixel,
  // then give samples that make no pixel time to leave the pipe too
  task automatic program_geometry(input logic [11:0] w, input logic [12:0] h,
                                  input logic [2:0] c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SOURCE_COLUMNS;
    cfg_data  <= CFG_DW'(w);
    @(posedge clk);
    cfg_index <= REG_SOURCE_ROWS;
    cfg_data  <= CFG_DW'(h);
    @(posedge clk);
    cfg_index <= REG_COLOR_COUNT;
    cfg_data  <= CFG_DW'(c);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate frames: zero width makes every pixel its own row
    program_geometry(12'd0, 13'd3, 3'd1);
    run_samples(3, FILL_RANDOM);
    // zero height keeps the row counter at zero, columns still wrap
    program_geometry(12'd8, 13'd0, 3'd1);
    run_samples(8, FILL_RANDOM);
    // too small for any interior target, color count zero acts as one
    program_geometry(12'd5, 13'd5, 3'd0);
    run_samples(25, FILL_RANDOM);

    // 8 x 8 frame, saturated input gives full-scale output
    program_geometry(12'd8, 13'd8, 3'd1);
    run_samples(64, FILL_WHITE);
    // color count above the limit acts as four channels
    program_geometry(12'd8, 13'd8, 3'd7);
    run_samples(256, FILL_EXTREMES);
    // odd geometry, the last source column and row are dropped
    program_geometry(12'd9, 13'd9, 3'd1);
    run_samples(81, FILL_RANDOM);

    // geometry shrunk mid-frame: stop at column 10 channel 0 of row 5, then
    // narrow to 8 x 1; the pending channel-1 sample still lands at column 10
    // and the column counter wraps on it, rows 6..11 then run at the new width;
    // this stretch runs with no idling on either channel
    steady <= 1'b1;
    program_geometry(12'd16, 13'd12, 3'd2);
    run_samples(181, FILL_RANDOM);
    program_geometry(12'd8, 13'd12, 3'd1);
    run_samples(49, FILL_RANDOM);
    steady <= 1'b0;

    // widest frame, written width saturates at the line store size; only the
    // start of row 0 is sent
    program_geometry(12'hFFF, 13'd8, 3'd1);
    run_samples(32, FILL_RANDOM);
    // tallest frame, written height saturates; the pending column 32 is past
    // the new width and wraps, rows 1..5 follow and give the first targets
    program_geometry(12'd8, 13'h1FFF, 3'd1);
    run_samples(41, FILL_RANDOM);

    in_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < DRAIN_LIMIT && outstanding != 0; n++) @(posedge clk);
    repeat (DRAIN_PAUSE * 2) @(posedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected pixels never arrived", $time, outstanding);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/gpr_pkg.sv
hdl/gpr_front.sv
hdl/gpr_queue.sv
hdl/gpr_back.sv
hdl/gaussian_pyramid_reduce_5x5_core.sv
verif/gpr_reduce_tb_pkg.sv
verif/gpr_reduce_checker.sv
verif/gaussian_pyramid_reduce_5x5_core_tb.sv
